// File: hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and helper functions for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Width of the value to convert and depth of the digit store.
  localparam int VALUE_BITS = 31;
  localparam int MAX_DIGITS = 31;

  // Derived widths.
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int IDX_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

  // Fixed field widths.
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  // Radix limits; requests outside are saturated.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // Character constants.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_LOWER = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CHAR_UPPER = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] CHAR_Z_LOW = CHAR_W'(122);
  localparam logic [RADIX_W-1:0] DEC_TEN   = RADIX_W'(10);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_SEND
  } rdc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new request
    logic div_step;   // one restoring division step
    logic emit_next;  // step to the next less significant digit
  } rdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bit_last;     // current step is the last of one division
    logic div_more;     // another digit must be produced
    logic digit_final;  // the digit being sent is the least significant one
  } rdc_status_t;

  // Map a digit value to its ASCII code.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d,
                                                       input logic lower);
    logic [CHAR_W-1:0] base;
    base = lower ? CHAR_LOWER : CHAR_UPPER;
    if (d < DEC_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end else begin
      return base + CHAR_W'(d - DEC_TEN);
    end
  endfunction

endpackage

// File: hw/rtl/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Bit-serial restoring divider, digit store and output digit formatting.
// ----------------------------------------------------------------------------
module rdc_datapath
  import rdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  rdc_cmd_t              cmd,
  output rdc_status_t           status,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [RADIX_W-1:0]    in_radix,
  input  logic                  in_lowercase,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic                  lower_r, lower_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [RADIX_W:0]      trial;
  logic                  trial_ge;
  logic [RADIX_W-1:0]    step_rem;
  logic [VALUE_BITS-1:0] step_quot;
  logic [RADIX_W-1:0]    radix_sat;

  logic [RADIX_W-1:0]    store_mem [MAX_DIGITS];
  logic [RADIX_W-1:0]    rd_data_r;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  store_we;

  // Saturate the requested radix into the supported range.
  always_comb begin
    if (in_radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_radix;
    end
  end

  // One restoring division step: shift in the next dividend bit and subtract.
  assign trial     = {rem_r, quot_r[VALUE_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, radix_r});
  assign step_rem  = trial_ge ? RADIX_W'(trial - {1'b0, radix_r}) : RADIX_W'(trial);
  assign step_quot = {quot_r[VALUE_BITS-2:0], trial_ge};

  // Status toward the controller.
  assign status.bit_last    = (bit_cnt_r == '0);
  assign status.div_more    = (step_quot != '0) && (cnt_r != CNT_W'(MAX_DIGITS - 1));
  assign status.digit_final = (cnt_r == CNT_W'(1));

  // Next-state logic of the datapath registers.
  always_comb begin
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    radix_nxt   = radix_r;
    lower_nxt   = lower_r;
    bit_cnt_nxt = bit_cnt_r;
    cnt_nxt     = cnt_r;
    if (cmd.load) begin
      quot_nxt    = in_value;
      rem_nxt     = '0;
      radix_nxt   = radix_sat;
      lower_nxt   = in_lowercase;
      bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS - 1);
      cnt_nxt     = '0;
    end else if (cmd.div_step) begin
      quot_nxt = step_quot;
      if (status.bit_last) begin
        // Remainder is complete: it goes to the store, next division starts.
        rem_nxt     = '0;
        bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS - 1);
        cnt_nxt     = cnt_r + CNT_W'(1);
      end else begin
        rem_nxt     = step_rem;
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
      end
    end else if (cmd.emit_next) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r    <= '0;
      cnt_r     <= '0;
      bit_cnt_r <= '0;
    end else begin
      quot_r    <= quot_nxt;
      cnt_r     <= cnt_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    lower_r <= lower_nxt;
  end

  // Digit store: written at the digit count, read at the digit to send.
  assign store_we = cmd.div_step && status.bit_last;
  assign wr_idx   = cnt_r[IDX_W-1:0];
  assign rd_idx   = IDX_W'(cnt_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[wr_idx] <= step_rem;
    end
    rd_data_r <= store_mem[rd_idx];
  end

  // Output formatting from the registered store data.
  assign out_digit_char = digit_to_ascii(rd_data_r, lower_r);
  assign out_last_digit = status.digit_final;

endmodule

// File: hw/rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Controller state machine: accept, divide per digit, then send the digits.
// ----------------------------------------------------------------------------
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  rdc_status_t status,
  output rdc_cmd_t    cmd
);

  rdc_state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.bit_last && !status.div_more) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) begin
          state_nxt = status.digit_final ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.emit_next = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_READ: begin
      end
      ST_SEND: begin
        out_valid     = 1'b1;
        cmd.emit_next = !out_stall && !status.digit_final;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a non-negative integer to ASCII digits in radix 2 to 36.
// ----------------------------------------------------------------------------
// Each digit is made by one pass of the bit-serial divider over the value bits.
// All digits of a request are divided first, then each digit is read from the
// store and then sent, and a send can be held by a stall on the result side.
// One request is converted at a time; the input is free again in the cycle
// after the last digit is taken.
// Synchronous active-low reset returns the controller to idle with no result.
module radix_digit_converter_core
  import rdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [RADIX_W-1:0]    in_radix,
  input  logic                  in_lowercase,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  rdc_cmd_t    cmd;
  rdc_status_t status;

  // Controller.
  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  rdc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_lowercase   (in_lowercase),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  // No new request is taken while digits are being sent.
  a_no_accept_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while digits are being sent");

  // An accepted request blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accepting a request");

  // Digits always lie in the code range from digit zero to lowercase z.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= CHAR_ZERO && out_digit_char <= CHAR_Z_LOW))
    else $error("digit character out of range");

  // After the final digit is taken the block is idle again.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_digit) |=> (!out_valid && !in_stall))
    else $error("block not idle after the final digit");

endmodule
